// ----- rtl/tsq_pkg.sv -----
// Package for the transmit/receive switching sequencer.
// Holds sizes, register indexes, phase codes and the transaction structs.
// No dependencies; every other file imports it.
package tsq_pkg;

   localparam int HISTORY_BITS    = 32;
   localparam int HANG_BITS       = 16;
   localparam int BLINK_BITS      = 7;
   localparam int BLINK_ON_TICKS  = 80;
   localparam int BLINK_OFF_TICKS = 100;
   localparam int DELAY_BITS      = 5;
   localparam int HANG_TICK_BITS  = 16;
   localparam int PHASE_BITS      = 4;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMP_ENGAGE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_DELAY  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HANG_TICKS = 2'd2;

   localparam logic [PHASE_BITS-1:0] PH_RX        = 4'd0;
   localparam logic [PHASE_BITS-1:0] PH_TX_EN     = 4'd1;
   localparam logic [PHASE_BITS-1:0] PH_AMP_EN    = 4'd2;
   localparam logic [PHASE_BITS-1:0] PH_PC        = 4'd3;
   localparam logic [PHASE_BITS-1:0] PH_PC_EXIT   = 4'd4;
   localparam logic [PHASE_BITS-1:0] PH_RAMP_UP   = 4'd5;
   localparam logic [PHASE_BITS-1:0] PH_STEADY    = 4'd6;
   localparam logic [PHASE_BITS-1:0] PH_RAMP_DOWN = 4'd7;
   localparam logic [PHASE_BITS-1:0] PH_TONE_END  = 4'd8;
   localparam logic [PHASE_BITS-1:0] PH_TONE_IDLE = 4'd9;
   localparam logic [PHASE_BITS-1:0] PH_HANG      = 4'd10;
   localparam logic [PHASE_BITS-1:0] PH_UNMUTE    = 4'd11;
   localparam logic [PHASE_BITS-1:0] PH_EXIT      = 4'd12;

   typedef struct packed {
      logic key_in;
      logic pc_request;
      logic inhibit;
      logic host_ready;
      logic tx_lo_available;
      logic ramp_up_done;
      logic ramp_down_done;
   } req_type;

   typedef struct packed {
      logic                  tx_enable;
      logic                  rx_enable;
      logic                  amp_release;
      logic                  led;
      logic [PHASE_BITS-1:0] phase_code;
      logic                  tx_lo_select;
      logic                  tone_phase_clear;
      logic                  rx_mute_start;
   } rsp_type;

   typedef struct packed {
      logic                      amp_engage;
      logic [DELAY_BITS-1:0]     key_delay;
      logic [HANG_TICK_BITS-1:0] hang_ticks;
   } cfg_type;

endpackage

// ----- rtl/tsq_in_stage.sv -----
// Input register of the sequencer: captures one request transaction.
// Depends on tsq_pkg for the request struct.
module tsq_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsq_pkg::req_type req_data,
   input  logic             out_ready,
   output logic             item_valid,
   output tsq_pkg::req_type item_data
);
   import tsq_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    can_load;

   always_comb begin
      can_load = !valid_ff || out_ready;
      valid_in = can_load ? req_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign req_stall  = !can_load;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// ----- rtl/tsq_core.sv -----
// Sequencing core: key history, phase machine and control levels.
// Updates its state once per tick and gives the tick's result combinationally.
// Depends on tsq_pkg.
module tsq_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  tsq_pkg::req_type item,
   input  tsq_pkg::cfg_type cfg,
   output tsq_pkg::rsp_type result
);
   import tsq_pkg::*;

   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [HISTORY_BITS-1:0] history_ff, history_in;
   logic [DELAY_BITS-1:0]   delay_ff, delay_in;
   logic                    amp_sel_ff, amp_sel_in;
   logic [HANG_BITS-1:0]    hang_ff, hang_in;
   logic [BLINK_BITS-1:0]   blink_ff, blink_in;
   logic                    pc_active_ff, pc_active_in;
   logic                    rx_ff, rx_in;
   logic                    tx_ff, tx_in;
   logic                    amp_ff, amp_in;
   logic                    led_ff, led_in;
   logic                    lo_ff, lo_in;

   logic [HISTORY_BITS-1:0] tap_vec;
   logic [HISTORY_BITS-1:0] shifted;
   logic                    tap_any;
   logic                    down;
   logic                    ptt;
   logic [BLINK_BITS-1:0]   blink_dec;
   logic [HANG_BITS-1:0]    hang_dec;
   logic                    clear_pulse;
   logic                    mute_pulse;

   always_comb begin
      for (int i = 0; i < HISTORY_BITS; i++) begin
         tap_vec[i] = (i == int'(delay_ff));
      end
      tap_any    = |tap_vec;
      shifted[0] = item.key_in;
      for (int i = 1; i < HISTORY_BITS; i++) begin
         shifted[i] = history_ff[i-1] && tap_any && ((i - 1) < int'(delay_ff));
      end
      down      = |(shifted & tap_vec);
      ptt       = |shifted;
      blink_dec = blink_ff - 1'b1;
      hang_dec  = hang_ff - 1'b1;
   end

   always_comb begin
      phase_in     = phase_ff;
      history_in   = shifted;
      delay_in     = delay_ff;
      amp_sel_in   = amp_sel_ff;
      hang_in      = hang_ff;
      blink_in     = blink_ff;
      pc_active_in = pc_active_ff;
      rx_in        = rx_ff;
      tx_in        = tx_ff;
      amp_in       = amp_ff;
      led_in       = led_ff;
      lo_in        = lo_ff;
      clear_pulse  = 1'b0;
      mute_pulse   = 1'b0;

      case (phase_ff)
         PH_RX: begin
            amp_sel_in = cfg.amp_engage;
            if (delay_ff != cfg.key_delay) begin
               delay_in   = cfg.key_delay;
               history_in = '0;
            end
            if (!item.inhibit && item.host_ready && (item.pc_request || item.key_in)) begin
               if (item.pc_request) begin
                  pc_active_in = 1'b1;
               end
               phase_in    = PH_TX_EN;
               clear_pulse = 1'b1;
               lo_in       = !item.pc_request && item.tx_lo_available;
               rx_in       = 1'b0;
            end
         end
         PH_TX_EN: begin
            tx_in    = 1'b1;
            phase_in = PH_AMP_EN;
         end
         PH_AMP_EN: begin
            if (amp_sel_ff) begin
               amp_in = 1'b0;
            end
            if (pc_active_ff) begin
               phase_in = PH_PC;
            end else if (down) begin
               phase_in = PH_RAMP_UP;
            end else begin
               phase_in = PH_TONE_IDLE;
            end
            blink_in = BLINK_BITS'(1);
         end
         PH_PC: begin
            if (item.pc_request) begin
               if (blink_dec == '0) begin
                  blink_in = led_ff ? BLINK_BITS'(BLINK_OFF_TICKS) : BLINK_BITS'(BLINK_ON_TICKS);
                  led_in   = !led_ff;
               end else begin
                  blink_in = blink_dec;
               end
            end else begin
               tx_in    = 1'b0;
               led_in   = 1'b0;
               amp_in   = 1'b1;
               phase_in = PH_PC_EXIT;
            end
         end
         PH_PC_EXIT: begin
            rx_in        = 1'b1;
            phase_in     = PH_RX;
            pc_active_in = 1'b0;
         end
         PH_RAMP_UP: begin
            if (item.ramp_up_done) begin
               phase_in = PH_STEADY;
            end
         end
         PH_STEADY: begin
            if (!down) begin
               phase_in    = PH_RAMP_DOWN;
               clear_pulse = 1'b1;
            end
         end
         PH_RAMP_DOWN: begin
            if (item.ramp_down_done) begin
               phase_in = PH_TONE_END;
            end
         end
         PH_TONE_END, PH_TONE_IDLE: begin
            clear_pulse = (phase_ff == PH_TONE_END);
            if (down) begin
               phase_in = PH_RAMP_UP;
            end else if (!ptt) begin
               if (cfg.hang_ticks == '0) begin
                  tx_in    = 1'b0;
                  led_in   = 1'b0;
                  amp_in   = 1'b1;
                  phase_in = PH_UNMUTE;
               end else begin
                  phase_in = PH_HANG;
                  hang_in  = HANG_BITS'(cfg.hang_ticks);
               end
            end
         end
         PH_HANG: begin
            if (down) begin
               phase_in = PH_RAMP_UP;
            end else if (ptt) begin
               phase_in = (delay_ff == '0) ? PH_RAMP_UP : PH_TONE_IDLE;
            end else begin
               hang_in = hang_dec;
               if (hang_dec == '0) begin
                  tx_in       = 1'b0;
                  led_in      = 1'b0;
                  amp_in      = 1'b1;
                  phase_in    = PH_UNMUTE;
                  clear_pulse = 1'b1;
               end
            end
         end
         PH_UNMUTE: begin
            if (ptt) begin
               phase_in = PH_TX_EN;
            end else begin
               rx_in       = 1'b1;
               phase_in    = PH_EXIT;
               clear_pulse = 1'b1;
               lo_in       = 1'b0;
            end
         end
         PH_EXIT: begin
            if (ptt) begin
               phase_in = PH_TX_EN;
               lo_in    = item.tx_lo_available;
               rx_in    = 1'b0;
            end else begin
               phase_in   = PH_RX;
               mute_pulse = 1'b1;
            end
         end
         default: begin
            phase_in = PH_RX;
         end
      endcase

      result.tx_enable        = tx_in;
      result.rx_enable        = rx_in;
      result.amp_release      = amp_in;
      result.led              = led_in;
      result.phase_code       = phase_in;
      result.tx_lo_select     = lo_in;
      result.tone_phase_clear = clear_pulse;
      result.rx_mute_start    = mute_pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RX;
         history_ff   <= '0;
         delay_ff     <= DELAY_BITS'(1);
         amp_sel_ff   <= 1'b0;
         hang_ff      <= '0;
         blink_ff     <= '0;
         pc_active_ff <= 1'b0;
         rx_ff        <= 1'b1;
         tx_ff        <= 1'b0;
         amp_ff       <= 1'b1;
         led_ff       <= 1'b0;
         lo_ff        <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         history_ff   <= history_in;
         delay_ff     <= delay_in;
         amp_sel_ff   <= amp_sel_in;
         hang_ff      <= hang_in;
         blink_ff     <= blink_in;
         pc_active_ff <= pc_active_in;
         rx_ff        <= rx_in;
         tx_ff        <= tx_in;
         amp_ff       <= amp_in;
         led_ff       <= led_in;
         lo_ff        <= lo_in;
      end
   end

   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(tx_ff && rx_ff))
      else $error("Transmitter and receiver are enabled together.");

   a_led_needs_tx: assert property (@(posedge clock) disable iff (reset)
      led_ff |-> tx_ff)
      else $error("LED is lit while the transmitter is off.");

   a_amp_needs_tx: assert property (@(posedge clock) disable iff (reset)
      !amp_ff |-> tx_ff)
      else $error("Amplifier is engaged while the transmitter is off.");

   a_tx_enable_step: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_TX_EN) |=> (tx_ff && phase_ff == PH_AMP_EN))
      else $error("Transmit enable phase did not enable the transmitter.");

endmodule

// ----- rtl/tsq_out_stage.sv -----
// Result register of the sequencer: holds one response transaction.
// Depends on tsq_pkg for the response struct.
module tsq_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  tsq_pkg::rsp_type result,
   output logic             out_ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsq_pkg::rsp_type rsp_data
);
   import tsq_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   always_comb begin
      out_ready = !valid_ff || !rsp_stall;
      valid_in  = out_ready ? advance : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/tx_rx_switch_sequencer.sv -----
// Top level of the transmit/receive switching sequencer.
// Holds the configuration registers and joins input stage, core and result stage.
// Depends on tsq_pkg, tsq_in_stage, tsq_core and tsq_out_stage.
//
// Each request transaction is one tick and yields exactly one response transaction
// showing the control levels after that tick and the pulses made during it. One
// tick is accepted every clock cycle while the response side does not stall; a
// request passes the input register, the single pass of phase logic and the
// result register. A stall on the response side holds the result register and
// then backs up into the input register, so throughput returns to one per cycle
// as soon as the stall drops. Configuration writes take effect on the next tick.
module tx_rx_switch_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tsq_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tsq_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [tsq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsq_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tsq_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    out_ready;
   logic    item_valid;
   req_type item_data;
   logic    advance;
   rsp_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_AMP_ENGAGE: cfg_in.amp_engage = csr_wdata[0];
            CSR_KEY_DELAY:  cfg_in.key_delay  = csr_wdata[DELAY_BITS-1:0];
            CSR_HANG_TICKS: cfg_in.hang_ticks = csr_wdata[HANG_TICK_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance = item_valid && out_ready;

   tsq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_ready  (out_ready),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   tsq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_data),
      .cfg     (cfg_ff),
      .result  (result)
   );

   tsq_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
